// File: rtl/nbgu_pkg.sv
// Shared types, constants and fixed-point helpers of the n-body update block.
`default_nettype none
package nbgu_pkg;

  localparam int FRAC_BITS   = 40;
  localparam int MAX_BODIES  = 64;
  localparam int IDX_W       = 6;
  localparam int STORE_DEPTH = 3 * MAX_BODIES;
  localparam int ADDR_W      = 8;
  localparam int CNT_W       = 7;

  localparam logic [6:0]  BODY_COUNT_RST   = 7'd64;
  localparam logic [31:0] GRAV_CONST_RST   = 32'd549756;
  localparam logic [62:0] MIN_DISTANCE_RST = 63'd1099511627776;
  localparam logic [7:0]  SPEED_FACTOR_RST = 8'd10;

  localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN  = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CFG_BODY_COUNT   = 2'd0,
    CFG_GRAV_CONST   = 2'd1,
    CFG_MIN_DISTANCE = 2'd2,
    CFG_SPEED_FACTOR = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOAD_WR, S_UPD_INIT, S_FETCH_O, S_SQV_MUL, S_SQV_ACC,
    S_SPD_MUL, S_FLIM, S_LOOP, S_FETCH_I, S_SQD_MUL, S_SQD_ACC, S_SQRT_INIT,
    S_SQRT, S_CMP, S_GM_MUL, S_DIVA_INIT, S_DIVA, S_SET_A, S_AD_MUL,
    S_DIVP_INIT, S_DIVP, S_ACC, S_NEXT, S_FINISH, S_WB, S_READBACK, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD_WR, OP_UPD_INIT, OP_FETCH_O, OP_MUL, OP_SQ_ACC,
    OP_FLIM, OP_CLR_SUM, OP_FETCH_I, OP_SQRT_INIT, OP_SQRT_STEP, OP_CRASH,
    OP_NEXT_I, OP_DIV_INIT_D2, OP_DIV_INIT_DIST, OP_DIV_STEP, OP_SET_A, OP_ACC,
    OP_FINISH, OP_WB, OP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [2:0] {
    M_SQV, M_SQD, M_SPD, M_GM, M_AD
  } msel_t;

  typedef struct packed {
    dp_op_t     op;
    msel_t      msel;
    logic [1:0] k;
    logic [1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic o_crashed;
    logic i_done;
    logic i_skip;
    logic hit;
    logic d2_zero;
    logic out_full;
  } dp_sts_t;

  function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SMIN : SAT63;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] ssub64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SMIN : SAT63;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] uadd63(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return s[63] ? SAT63 : s;
  endfunction

  function automatic logic [63:0] sat63w(input logic [127:0] v);
    return (v[127:63] != '0) ? SAT63 : v[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/nbgu_ctrl.sv
// Sequencer that steps the datapath through load, force sum and write-back.
`default_nettype none
module nbgu_ctrl import nbgu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [1:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 7'd1;
      case (state)
        S_SQV_ACC, S_SQD_ACC, S_ACC: k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        S_SQV_MUL, S_SQD_MUL, S_AD_MUL, S_DIVP_INIT, S_DIVP: k <= k;
        default: k <= '0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (!sts.mode) state_next = S_LOAD_WR;
        else if (sts.o_crashed) state_next = S_READBACK;
        else state_next = S_UPD_INIT;
      end
      S_LOAD_WR:   if (cnt == 7'd2) state_next = S_READBACK;
      S_UPD_INIT:  state_next = S_FETCH_O;
      S_FETCH_O:   if (cnt == 7'd3) state_next = S_SQV_MUL;
      S_SQV_MUL:   if (cnt == 7'd3) state_next = S_SQV_ACC;
      S_SQV_ACC:   state_next = (k == 2'd2) ? S_SPD_MUL : S_SQV_MUL;
      S_SPD_MUL:   if (cnt == 7'd3) state_next = S_FLIM;
      S_FLIM:      state_next = S_LOOP;
      S_LOOP: begin
        if (sts.i_done) state_next = S_FINISH;
        else if (sts.i_skip) state_next = S_NEXT;
        else state_next = S_FETCH_I;
      end
      S_FETCH_I:   if (cnt == 7'd3) state_next = S_SQD_MUL;
      S_SQD_MUL:   if (cnt == 7'd3) state_next = S_SQD_ACC;
      S_SQD_ACC:   state_next = (k == 2'd2) ? S_SQRT_INIT : S_SQD_MUL;
      S_SQRT_INIT: state_next = S_SQRT;
      S_SQRT:      if (cnt == 7'd63) state_next = S_CMP;
      S_CMP:       state_next = (sts.hit || sts.d2_zero) ? S_NEXT : S_GM_MUL;
      S_GM_MUL:    if (cnt == 7'd3) state_next = S_DIVA_INIT;
      S_DIVA_INIT: state_next = S_DIVA;
      S_DIVA:      if (cnt == 7'd127) state_next = S_SET_A;
      S_SET_A:     state_next = S_AD_MUL;
      S_AD_MUL:    if (cnt == 7'd3) state_next = S_DIVP_INIT;
      S_DIVP_INIT: state_next = S_DIVP;
      S_DIVP:      if (cnt == 7'd127) state_next = S_ACC;
      S_ACC:       state_next = (k == 2'd2) ? S_NEXT : S_AD_MUL;
      S_NEXT:      state_next = S_LOOP;
      S_FINISH:    state_next = S_WB;
      S_WB:        if (cnt == 7'd2) state_next = S_READBACK;
      S_READBACK:  if (cnt == 7'd3) state_next = S_OUT;
      S_OUT:       if (!sts.out_full) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.op   = OP_NONE;
    cmd.msel = M_SQV;
    cmd.k    = k;
    cmd.step = cnt[1:0];
    case (state)
      S_IDLE:      if (in_valid) cmd.op = OP_CAPTURE;
      S_LOAD_WR:   cmd.op = OP_LOAD_WR;
      S_UPD_INIT:  cmd.op = OP_UPD_INIT;
      S_FETCH_O:   cmd.op = OP_FETCH_O;
      S_READBACK:  cmd.op = OP_FETCH_O;
      S_SQV_MUL:   cmd.op = OP_MUL;
      S_SQV_ACC:   cmd.op = OP_SQ_ACC;
      S_SQD_ACC:   cmd.op = OP_SQ_ACC;
      S_SPD_MUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_SPD;
      end
      S_FLIM:      cmd.op = OP_FLIM;
      S_LOOP:      if (!sts.i_done && !sts.i_skip) cmd.op = OP_CLR_SUM;
      S_FETCH_I:   cmd.op = OP_FETCH_I;
      S_SQD_MUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_SQD;
      end
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT_STEP;
      S_CMP:       if (sts.hit) cmd.op = OP_CRASH;
      S_GM_MUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_GM;
      end
      S_DIVA_INIT: cmd.op = OP_DIV_INIT_D2;
      S_DIVA:      cmd.op = OP_DIV_STEP;
      S_DIVP:      cmd.op = OP_DIV_STEP;
      S_SET_A:     cmd.op = OP_SET_A;
      S_AD_MUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_AD;
      end
      S_DIVP_INIT: cmd.op = OP_DIV_INIT_DIST;
      S_ACC:       cmd.op = OP_ACC;
      S_NEXT:      cmd.op = OP_NEXT_I;
      S_FINISH:    cmd.op = OP_FINISH;
      S_WB:        cmd.op = OP_WB;
      S_OUT:       if (!sts.out_full) cmd.op = OP_OUT_LOAD;
      default:     cmd.op = OP_NONE;
    endcase
  end

  a_k_range: assert property (@(posedge clk) disable iff (rst) k != 2'd3)
    else $error("component counter out of range");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !sts.out_full) |=> state == S_IDLE)
    else $error("result handoff did not return to idle");
  a_sqrt_len: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT |-> cnt <= 7'd63)
    else $error("root iteration overran");

endmodule
`default_nettype wire

// File: rtl/nbgu_dp.sv
// Datapath: body stores, shared multiplier, root and divider units, result register.
`default_nettype none
module nbgu_dp import nbgu_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire dp_cmd_t      cmd,
  output dp_sts_t           sts,
  input  wire logic [455:0] s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         cfg_valid,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [391:0]      m_tdata
);

  logic [6:0]  body_count;
  logic [31:0] grav_const;
  logic [62:0] min_distance;
  logic [7:0]  speed_factor;
  logic [6:0]  n_eff;

  logic             mode;
  logic [IDX_W-1:0] o;
  logic [63:0]      in_pos [3];
  logic [63:0]      in_vel [3];
  logic [62:0]      in_mass;
  logic             in_crash;

  logic [63:0] p [3];
  logic [63:0] v [3];
  logic [63:0] acc [3];
  logic [63:0] d [3];
  logic [6:0]   i;
  logic [63:0]  ssum, flim, a;
  logic [127:0] prod;
  logic [127:0] sn;
  logic [67:0]  srem;
  logic [63:0]  sroot;
  logic [127:0] dn, dq;
  logic [63:0]  dr, dd;
  logic [MAX_BODIES-1:0] crash_flags;

  logic [63:0]  pos_mem [STORE_DEPTH];
  logic [63:0]  vel_mem [STORE_DEPTH];
  logic [62:0]  mass_mem [MAX_BODIES];
  logic [63:0]  pos_rd, vel_rd;
  logic [62:0]  mass_rd;

  logic [ADDR_W-1:0] base_o, base_i, wa, ra;
  logic              mem_we;
  logic [63:0]       pos_wd, vel_wd;
  logic [1:0]        prev;

  logic [63:0]  ma, mb;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] mul_term;
  logic [67:0]  rem2, rtest;
  logic [64:0]  rt;
  logic [63:0]  q, sq_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_count   <= BODY_COUNT_RST;
      grav_const   <= GRAV_CONST_RST;
      min_distance <= MIN_DISTANCE_RST;
      speed_factor <= SPEED_FACTOR_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BODY_COUNT:   body_count   <= cfg_data[6:0];
        CFG_GRAV_CONST:   grav_const   <= cfg_data[31:0];
        CFG_MIN_DISTANCE: min_distance <= cfg_data[62:0];
        CFG_SPEED_FACTOR: speed_factor <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign n_eff  = (body_count > 7'(MAX_BODIES)) ? 7'(MAX_BODIES) : body_count;
  assign base_o = {2'b00, o} + {1'b0, o, 1'b0};
  assign base_i = {2'b00, i[IDX_W-1:0]} + {1'b0, i[IDX_W-1:0], 1'b0};
  assign prev   = cmd.step - 2'd1;

  always_comb begin
    mem_we = (cmd.op == OP_LOAD_WR) || (cmd.op == OP_WB);
    wa     = base_o + {6'b0, cmd.step};
    ra     = ((cmd.op == OP_FETCH_I) ? base_i : base_o) + {6'b0, cmd.step};
    pos_wd = (cmd.op == OP_WB) ? p[cmd.step] : in_pos[cmd.step];
    vel_wd = (cmd.op == OP_WB) ? v[cmd.step] : in_vel[cmd.step];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pos_mem[wa] <= pos_wd;
      vel_mem[wa] <= vel_wd;
    end
    pos_rd <= pos_mem[ra];
    vel_rd <= vel_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_WR && cmd.step == 2'd0) begin
      mass_mem[o] <= in_mass;
    end
    mass_rd <= mass_mem[i[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crash_flags <= '0;
    end else if (cmd.op == OP_LOAD_WR && cmd.step == 2'd0) begin
      crash_flags[o] <= in_crash;
    end else if (cmd.op == OP_CRASH) begin
      crash_flags[o] <= 1'b1;
    end
  end

  always_comb begin
    case (cmd.msel)
      M_SQV: begin
        ma = mag64(v[cmd.k]);
        mb = ma;
      end
      M_SQD: begin
        ma = mag64(d[cmd.k]);
        mb = ma;
      end
      M_SPD: begin
        ma = ssum;
        mb = {56'b0, speed_factor};
      end
      M_GM: begin
        ma = {32'b0, grav_const};
        mb = {1'b0, mass_rd};
      end
      M_AD: begin
        ma = a;
        mb = mag64(d[cmd.k]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    pa = cmd.step[1] ? ma[63:32] : ma[31:0];
    pb = cmd.step[0] ? mb[63:32] : mb[31:0];
    pp = pa * pb;
    case (cmd.step)
      2'd0:    mul_term = {64'b0, pp};
      2'd3:    mul_term = {pp, 64'b0};
      default: mul_term = {32'b0, pp, 32'b0};
    endcase
    rem2  = {srem[65:0], sn[127:126]};
    rtest = {2'b00, sroot, 2'b01};
    rt    = {dr, dn[127]};
    q     = sat63w(dq);
    sq_q  = sat63w(prod >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        mode      <= s_tuser;
        o         <= s_tdata[5:0];
        in_pos[0] <= s_tdata[69:6];
        in_pos[1] <= s_tdata[133:70];
        in_pos[2] <= s_tdata[197:134];
        in_vel[0] <= s_tdata[261:198];
        in_vel[1] <= s_tdata[325:262];
        in_vel[2] <= s_tdata[389:326];
        in_mass   <= s_tdata[452:390];
        in_crash  <= s_tdata[453];
      end
      OP_UPD_INIT: begin
        acc[0] <= '0;
        acc[1] <= '0;
        acc[2] <= '0;
        ssum   <= '0;
        i      <= '0;
      end
      OP_FETCH_O: begin
        if (cmd.step != 2'd0) begin
          p[prev] <= pos_rd;
          v[prev] <= vel_rd;
        end
      end
      OP_MUL:     prod <= ((cmd.step == 2'd0) ? 128'b0 : prod) + mul_term;
      OP_SQ_ACC:  ssum <= uadd63(ssum, sq_q);
      OP_FLIM:    flim <= sat63w(prod);
      OP_CLR_SUM: ssum <= '0;
      OP_FETCH_I: begin
        if (cmd.step != 2'd0) begin
          d[prev] <= ssub64(pos_rd, p[prev]);
        end
      end
      OP_SQRT_INIT: begin
        sn    <= {64'b0, ssum} << FRAC_BITS;
        srem  <= '0;
        sroot <= '0;
      end
      OP_SQRT_STEP: begin
        sn <= {sn[125:0], 2'b00};
        if (rem2 >= rtest) begin
          srem  <= rem2 - rtest;
          sroot <= {sroot[62:0], 1'b1};
        end else begin
          srem  <= rem2;
          sroot <= {sroot[62:0], 1'b0};
        end
      end
      OP_NEXT_I: i <= i + 7'd1;
      OP_DIV_INIT_D2, OP_DIV_INIT_DIST: begin
        dn <= prod;
        dr <= '0;
        dq <= '0;
        dd <= (cmd.op == OP_DIV_INIT_D2) ? ssum : sroot;
      end
      OP_DIV_STEP: begin
        dn <= {dn[126:0], 1'b0};
        if (rt >= {1'b0, dd}) begin
          dr <= 64'(rt - {1'b0, dd});
          dq <= {dq[126:0], 1'b1};
        end else begin
          dr <= rt[63:0];
          dq <= {dq[126:0], 1'b0};
        end
      end
      OP_SET_A: a <= q;
      OP_ACC:   acc[cmd.k] <= sadd64(acc[cmd.k], d[cmd.k][63] ? (~q + 64'd1) : q);
      OP_FINISH: begin
        for (int c = 0; c < 3; c++) begin
          p[c] <= sadd64(p[c], v[c]);
          v[c] <= sadd64(v[c], acc[c]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT_LOAD) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_LOAD) begin
      m_tdata <= {1'b0, crash_flags[o], v[2], v[1], v[0], p[2], p[1], p[0], o};
    end
  end

  always_comb begin
    sts.mode      = mode;
    sts.o_crashed = crash_flags[o];
    sts.i_done    = (i >= n_eff);
    sts.i_skip    = (i[IDX_W-1:0] == o) || crash_flags[i[IDX_W-1:0]];
    sts.hit       = (sroot < {1'b0, min_distance}) || (ssum < flim);
    sts.d2_zero   = (ssum == 64'd0);
    sts.out_full  = m_tvalid;
  end

  a_crash_set: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_CRASH |=> crash_flags[o])
    else $error("crash flag not recorded");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT_LOAD |=> m_tvalid)
    else $error("result not presented");
  a_finish_sum: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FINISH |-> i >= n_eff)
    else $error("step finished before the force sum");

endmodule
`default_nettype wire

// File: rtl/nbody_gravity_body_update_top.sv
// Top level of the n-body update block: sequencer plus datapath.
// A load stores the body and returns it as read back; an update of a crashed body returns it unchanged.
// An update sums the pull of every other live body; skipped bodies and bodies that crash it or
// coincide with it add nothing. Each other live body takes one 128-step divide for the pull and
// three for the components, and a 64-step root. One item is in work at a time.
// The result register lets the next item be accepted while a result waits.
// Reset clears the crashed flags and the handshake state and sets the configuration registers to their defaults.
`default_nettype none
module nbody_gravity_body_update_top import nbgu_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [455:0] s_tdata,   // body_index, pos_x/y/z_in, vel_x/y/z_in, mass_in, crashed_in
  input  wire logic         s_tuser,   // mode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [391:0]      m_tdata,   // body_out, pos_x/y/z_out, vel_x/y/z_out, crashed_out
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  nbgu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nbgu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire
